// ----- hdl/latency_bounded_beacon_store_defines.svh -----
// Assertion macros for the beacon store.
// Uses i_clk and i_rst_n of the module that expands them.
`ifndef LATENCY_BOUNDED_BEACON_STORE_DEFINES_SVH
`define LATENCY_BOUNDED_BEACON_STORE_DEFINES_SVH

// condition holds at every edge outside reset
`define LBBS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// same-cycle implication
`define LBBS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LBBS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/lbbs_pkg.sv -----
// Package for the beacon store: sizes, entry/row types, request/result structs.
// No dependencies.
package lbbs_pkg;

    localparam int NUM_DST    = 64;
    localparam int NUM_IFACES = 16;
    localparam int SLOTS      = 8;

    localparam int NBKT   = NUM_DST * NUM_IFACES;
    localparam int BKT_W  = (NBKT > 1) ? $clog2(NBKT) : 1;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FILL_W = $clog2(SLOTS + 1);

    localparam int DST_W = 6;
    localparam int ING_W = 4;
    localparam int ID_W  = 16;
    localparam int LAT_W = 32;
    localparam int CAP_W = 4;

    localparam int IN_W  = 64;
    localparam int OUT_W = 56;

    localparam logic [CAP_W-1:0] CAP_RST = CAP_W'(8);

    localparam logic OP_OFFER  = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [LAT_W-1:0] lat;
    } t_entry;

    typedef t_entry [SLOTS-1:0] t_row;

    typedef struct packed {
        logic             op;
        logic             in_range;
        logic [ID_W-1:0]  id;
        logic [LAT_W-1:0] lat;
    } t_req;

    typedef struct packed {
        logic             accepted;
        logic             evicted;
        logic [ID_W-1:0]  ev_id;
        logic [LAT_W-1:0] ev_lat;
        logic             removed;
    } t_result;

    // zero reads as one, anything above SLOTS saturates
    function automatic logic [FILL_W-1:0] f_eff_cap(input logic [CAP_W-1:0] c);
        logic [FILL_W-1:0] r;
        if (c == '0) begin
            r = FILL_W'(1);
        end else if (int'(c) > SLOTS) begin
            r = FILL_W'(SLOTS);
        end else begin
            r = FILL_W'(c);
        end
        return r;
    endfunction

endpackage

// ----- hdl/latency_bounded_beacon_store.sv -----
// Latency-bounded beacon store top level: handshake, control, bucket memories.
// Depends on lbbs_pkg, lbbs_ram, lbbs_update and the assertion macro header.
//
// Keeps up to bucket_capacity beacons per (destination, ingress) bucket, sorted
// by latency. One bucket row (all slots) lives in one word of the row RAM, the
// fill count in a separate RAM. An item goes through accept and row read,
// compare, then write-back with the result loaded into the output register; the
// write-back waits while an earlier result is still held. After reset the fill
// table is cleared one bucket per cycle, all NBKT buckets, before the first item
// is taken; configuration writes are taken at any time.
`include "latency_bounded_beacon_store_defines.svh"

module latency_bounded_beacon_store import lbbs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CAP_W-1:0] i_cfg_wr_data,   // bucket_capacity
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,    // dst_index, ingress_index, beacon_id, path_latency
    input  logic             s_axis_tuser,    // operation
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata     // accepted, evicted, evicted_id,
                                              // evicted_latency, removed
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_CMP   = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [BKT_W-1:0] r_clr_cnt;
    logic [CAP_W-1:0] r_cap;
    logic [BKT_W-1:0] r_bkt;
    t_req             r_req;
    logic             r_out_valid;
    t_result          r_out;

    logic [DST_W-1:0] in_dst;
    logic [ING_W-1:0] in_ing;
    logic [BKT_W-1:0] in_bkt;
    t_req             in_req;
    logic             in_acc, wr_go;

    t_row              rd_row, upd_row;
    logic [FILL_W-1:0] rd_fill, upd_fill, fill_wdata;
    logic [BKT_W-1:0]  fill_waddr;
    logic              fill_we, row_we, upd_wr;
    t_result           upd_res;

    assign in_dst = s_axis_tdata[DST_W-1:0];
    assign in_ing = s_axis_tdata[DST_W+ING_W-1:DST_W];
    assign in_bkt = BKT_W'(int'(in_dst) * NUM_IFACES + int'(in_ing));

    always_comb begin
        in_req.op       = s_axis_tuser;
        in_req.in_range = (int'(in_dst) < NUM_DST) && (int'(in_ing) < NUM_IFACES);
        in_req.id       = s_axis_tdata[DST_W+ING_W+ID_W-1:DST_W+ING_W];
        in_req.lat      = s_axis_tdata[DST_W+ING_W+ID_W+LAT_W-1:DST_W+ING_W+ID_W];
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign wr_go         = (r_state == ST_WRITE) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_cnt == BKT_W'(NBKT - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_acc) n_state = ST_CMP;
            end
            ST_CMP: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (wr_go) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_cap       <= CAP_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + BKT_W'(1);
            end
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (wr_go) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_bkt <= in_bkt;
            r_req <= in_req;
        end
        if (wr_go) begin
            r_out <= upd_res;
        end
    end

    assign row_we     = wr_go && upd_wr;
    assign fill_we    = (r_state == ST_CLEAR) || row_we;
    assign fill_waddr = (r_state == ST_CLEAR) ? r_clr_cnt : r_bkt;
    assign fill_wdata = (r_state == ST_CLEAR) ? '0 : upd_fill;

    lbbs_ram #(
        .WIDTH ($bits(t_row)),
        .DEPTH (NBKT)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (r_bkt),
        .i_wdata (upd_row),
        .i_re    (in_acc),
        .i_raddr (in_bkt),
        .o_rdata (rd_row)
    );

    lbbs_ram #(
        .WIDTH (FILL_W),
        .DEPTH (NBKT)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (fill_waddr),
        .i_wdata (fill_wdata),
        .i_re    (in_acc),
        .i_raddr (in_bkt),
        .o_rdata (rd_fill)
    );

    lbbs_update u_update (
        .i_clk    (i_clk),
        .i_cmp_en (r_state == ST_CMP),
        .i_req    (r_req),
        .i_row    (rd_row),
        .i_fill   (rd_fill),
        .i_cap    (f_eff_cap(r_cap)),
        .o_row    (upd_row),
        .o_fill   (upd_fill),
        .o_wr     (upd_wr),
        .o_res    (upd_res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_W - 3 - ID_W - LAT_W)'(0), r_out.removed, r_out.ev_lat,
                            r_out.ev_id, r_out.evicted, r_out.accepted};

    `LBBS_ASSERT_IMP(a_no_accept_in_clear, r_state == ST_CLEAR, !s_axis_tready, "accept during clear")
    `LBBS_ASSERT_NXT(a_accept_to_cmp, in_acc, r_state == ST_CMP, "accept not followed by compare")
    `LBBS_ASSERT_IMP(a_row_we_in_write, row_we, r_state == ST_WRITE && !fill_we == 1'b0, "stray row write")
    `LBBS_ASSERT_IMP(a_fill_bound, row_we, int'(upd_fill) <= SLOTS, "fill above slot count")
    `LBBS_ASSERT_IMP(a_out_from_write, $rose(r_out_valid), $past(r_state) == ST_WRITE, "result without write-back")

endmodule

// ----- hdl/lbbs_ram.sv -----
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module lbbs_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/lbbs_update.sv -----
// Bucket row update: registered compare stage, then insert/evict/delete of the row.
// Depends on lbbs_pkg.
module lbbs_update import lbbs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_cmp_en,
    input  t_req              i_req,
    input  t_row              i_row,
    input  logic [FILL_W-1:0] i_fill,
    input  logic [FILL_W-1:0] i_cap,
    output t_row              o_row,
    output logic [FILL_W-1:0] o_fill,
    output logic              o_wr,
    output t_result           o_res
);

    logic [SLOTS-1:0] n_gt, n_eq;
    logic [SLOTS-1:0] r_gt, r_eq;
    logic             r_full;
    t_row             r_row;
    logic [FILL_W-1:0] r_fill;
    t_req             r_req;

    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            n_gt[k] = (FILL_W'(k) < i_fill) && (i_row[k].lat > i_req.lat);
            n_eq[k] = (FILL_W'(k) < i_fill) && (i_row[k].lat == i_req.lat)
                      && (i_row[k].id == i_req.id);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmp_en) begin
            r_gt   <= n_gt;
            r_eq   <= n_eq;
            r_full <= (i_fill >= i_cap);
            r_row  <= i_row;
            r_fill <= i_fill;
            r_req  <= i_req;
        end
    end

    logic              is_offer, evict, ins, match;
    logic [FILL_W-1:0] eff, last;
    logic [SLOTS-1:0]  after;
    t_row              ins_row, del_row;
    t_entry            new_ent, worst;
    logic              run;
    int                prev;

    assign is_offer = (r_req.op == OP_OFFER);
    assign evict    = is_offer && r_full && (|r_gt);
    assign ins      = is_offer && (!r_full || evict);
    assign match    = (r_req.op == OP_REMOVE) && (|r_eq);
    assign eff      = evict ? r_fill - FILL_W'(1) : r_fill;
    assign last     = r_fill - FILL_W'(1);
    assign worst    = r_row[last[SLOT_W-1:0]];
    assign new_ent  = '{id: r_req.id, lat: r_req.lat};

    always_comb begin
        run  = 1'b0;
        prev = 0;
        for (int k = 0; k < SLOTS; k++) begin
            after[k] = (FILL_W'(k) < eff) ? r_gt[k] : 1'b1;
        end
        for (int k = 0; k < SLOTS; k++) begin
            prev = (k == 0) ? 0 : k - 1;
            if (!after[k]) begin
                ins_row[k] = r_row[k];
            end else if (k == 0 || !after[prev]) begin
                ins_row[k] = new_ent;
            end else begin
                ins_row[k] = r_row[prev];
            end
        end
        for (int k = 0; k < SLOTS; k++) begin
            run = run | r_eq[k];
            if (run && k < SLOTS - 1) begin
                del_row[k] = r_row[(k < SLOTS - 1) ? k + 1 : k];
            end else begin
                del_row[k] = r_row[k];
            end
        end
    end

    always_comb begin
        o_row  = ins ? ins_row : del_row;
        o_wr   = r_req.in_range && (ins || match);
        o_fill = r_fill;
        if (ins && !evict) begin
            o_fill = r_fill + FILL_W'(1);
        end else if (match) begin
            o_fill = r_fill - FILL_W'(1);
        end
        o_res          = '0;
        if (r_req.in_range) begin
            o_res.accepted = ins;
            o_res.evicted  = evict;
            o_res.ev_id    = evict ? worst.id : '0;
            o_res.ev_lat   = evict ? worst.lat : '0;
            o_res.removed  = match;
        end
    end

endmodule

// ----- tb/sv/lbbs_checker.sv -----
// Checker for the beacon store: watches the config port and both stream channels,
// predicts each result from its own copy of the bucket tables and compares it.
// Depends on lbbs_pkg.
`timescale 1ns / 100ps

module lbbs_checker import lbbs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CAP_W-1:0] i_cfg_wr_data,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [IN_W-1:0]  i_in_data,
    input  logic             i_in_user,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [OUT_W-1:0] i_out_data,
    output int               o_fail_count,
    output int               o_pending
);

    logic [LAT_W-1:0] lat_tbl [0:NBKT-1][0:SLOTS-1];
    logic [ID_W-1:0]  id_tbl  [0:NBKT-1][0:SLOTS-1];
    int               fill_tbl [0:NBKT-1];
    logic [CAP_W-1:0] capacity;
    t_result          outcome_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
        o_fail_count++;
    endtask

    // sorted insert into the first n slots, after every entry of equal or lower latency
    function automatic void place_beacon(input int b, input int n,
                                         input logic [ID_W-1:0] id,
                                         input logic [LAT_W-1:0] lat);
        int p;
        p = n;
        while (p > 0 && lat_tbl[b][p-1] > lat) begin
            lat_tbl[b][p] = lat_tbl[b][p-1];
            id_tbl[b][p]  = id_tbl[b][p-1];
            p--;
        end
        lat_tbl[b][p] = lat;
        id_tbl[b][p]  = id;
    endfunction

    function automatic t_result apply_beacon_op(input logic op,
                                                input logic [DST_W-1:0] dst,
                                                input logic [ING_W-1:0] ing,
                                                input logic [ID_W-1:0] id,
                                                input logic [LAT_W-1:0] lat);
        t_result r;
        int      b;
        int      n;
        int      cap;
        int      k;
        int      hit;
        r   = '0;
        b   = int'(dst) * NUM_IFACES + int'(ing);
        n   = fill_tbl[b];
        cap = (capacity == '0) ? 1 : ((int'(capacity) > SLOTS) ? SLOTS : int'(capacity));
        if (op == OP_OFFER) begin
            if (n < cap) begin
                place_beacon(b, n, id, lat);
                fill_tbl[b] = n + 1;
                r.accepted  = 1'b1;
            end else if (n > 0 && lat_tbl[b][n-1] > lat) begin
                r.accepted = 1'b1;
                r.evicted  = 1'b1;
                r.ev_id    = id_tbl[b][n-1];
                r.ev_lat   = lat_tbl[b][n-1];
                place_beacon(b, n - 1, id, lat);
            end
        end else begin
            hit = -1;
            for (k = 0; k < n; k++) begin
                if (hit < 0 && lat_tbl[b][k] == lat && id_tbl[b][k] == id) begin
                    hit = k;
                end
            end
            if (hit >= 0) begin
                for (k = hit; k + 1 < n; k++) begin
                    lat_tbl[b][k] = lat_tbl[b][k+1];
                    id_tbl[b][k]  = id_tbl[b][k+1];
                end
                fill_tbl[b] = n - 1;
                r.removed   = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            for (int b = 0; b < NBKT; b++) begin
                fill_tbl[b] = 0;
            end
            capacity = CAP_RST;
            outcome_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (outcome_q.size() == 0) begin
                    report_mismatch("result beat with nothing pending", 64'(i_out_data), 64'd0);
                end else begin
                    want = outcome_q.pop_front();
                    if (i_out_data[0] !== want.accepted)
                        report_mismatch("accepted", 64'(i_out_data[0]), 64'(want.accepted));
                    if (i_out_data[1] !== want.evicted)
                        report_mismatch("evicted", 64'(i_out_data[1]), 64'(want.evicted));
                    if (i_out_data[17:2] !== want.ev_id)
                        report_mismatch("evicted_id", 64'(i_out_data[17:2]), 64'(want.ev_id));
                    if (i_out_data[49:18] !== want.ev_lat)
                        report_mismatch("evicted_latency", 64'(i_out_data[49:18]),
                                        64'(want.ev_lat));
                    if (i_out_data[50] !== want.removed)
                        report_mismatch("removed", 64'(i_out_data[50]), 64'(want.removed));
                end
            end
            if (i_in_valid && i_in_ready) begin
                outcome_q.push_back(apply_beacon_op(i_in_user, i_in_data[5:0],
                                                    i_in_data[9:6], i_in_data[25:10],
                                                    i_in_data[57:26]));
            end
            if (i_cfg_wr_en) begin
                capacity = i_cfg_wr_data;
            end
        end
        o_pending = outcome_q.size();
    end

endmodule

// ----- tb/sv/tb.sv -----
// Top of the beacon store testbench: clock, reset, offer/remove stimulus with bursty
// input and stalling output, capacity phases and the verdict.
// Depends on lbbs_pkg, lbbs_checker and latency_bounded_beacon_store.
`timescale 1ns / 100ps

module tb import lbbs_pkg::*; ();

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 100;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0] i_cfg_wr_data = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;   // dst_index, ingress_index, beacon_id, path_latency
    logic             s_axis_tuser  = 1'b0; // operation
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;         // accepted, evicted, evicted_id,
                                            // evicted_latency, removed
    int               fail_count;
    int               pending;

    int               cycle_count   = 0;
    int               burst_left    = 0;
    bit               rx_hold_req   = 1'b0;
    int               rx_hold_left  = 0;
    int               rx_mode       = 0;
    int               rx_mode_left  = 0;

    logic [9:0]       hot_bkt [0:5];
    logic [9:0]       hist_bkt [0:63];
    logic [ID_W-1:0]  hist_id  [0:63];
    logic [LAT_W-1:0] hist_lat [0:63];
    int               hist_n   = 0;
    int               hist_wr  = 0;

    latency_bounded_beacon_store i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lbbs_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_in_user     (s_axis_tuser),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: long hold-off on request, otherwise a changing stall pattern
    always @(posedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_req  = 1'b0;
            rx_hold_left = 400;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 200);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 9) == 0);
                default: m_axis_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    task automatic send_beat(input logic op, input logic [DST_W-1:0] dst,
                             input logic [ING_W-1:0] ing, input logic [ID_W-1:0] id,
                             input logic [LAT_W-1:0] lat);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= IN_W'({lat, id, ing, dst});
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [LAT_W-1:0] pick_latency();
        logic [LAT_W-1:0] lat;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: lat = 32'd10 * $urandom_range(1, 6);
            4, 5, 6:    lat = $urandom_range(0, 1000);
            7, 8:       lat = $urandom;
            default:    lat = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
        endcase
        return lat;
    endfunction

    // mostly offers and removes of known beacons into a few hot buckets
    task automatic run_random_phase(input int count, input bit with_hold);
        logic             op;
        logic [9:0]       bkt;
        logic [ID_W-1:0]  id;
        logic [LAT_W-1:0] lat;
        int               k;
        for (int h = 2; h < 6; h++) begin
            hot_bkt[h] = 10'($urandom);
        end
        for (int i = 0; i < count; i++) begin
            if (with_hold && i == 10) begin
                rx_hold_req = 1'b1;
            end
            if (i == count / 2) begin
                wait_idle();
            end
            op  = ($urandom_range(0, 9) < 3) ? OP_REMOVE : OP_OFFER;
            bkt = ($urandom_range(0, 99) < 85) ? hot_bkt[$urandom_range(0, 5)]
                                               : 10'($urandom);
            id  = ($urandom_range(0, 1) != 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 7));
            lat = pick_latency();
            if (op == OP_REMOVE && hist_n > 0 && $urandom_range(0, 3) != 0) begin
                k   = $urandom_range(0, hist_n - 1);
                bkt = hist_bkt[k];
                id  = hist_id[k];
                lat = hist_lat[k];
            end else if (op == OP_OFFER) begin
                hist_bkt[hist_wr] = bkt;
                hist_id[hist_wr]  = id;
                hist_lat[hist_wr] = lat;
                hist_wr = (hist_wr + 1) % 64;
                if (hist_n < 64) hist_n++;
            end
            send_beat(op, bkt[9:4], bkt[3:0], id, lat);
        end
    endtask

    initial begin
        logic [CAP_W-1:0] phase_cap [0:5];
        phase_cap[0] = 4'd1;
        phase_cap[1] = 4'd8;
        phase_cap[2] = 4'd3;
        phase_cap[3] = 4'd0;
        phase_cap[4] = 4'd15;
        phase_cap[5] = 4'($urandom_range(1, 15));
        hot_bkt[0] = 10'h000;
        hot_bkt[1] = 10'h3FF;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: ties, rejects, evictions, removes, extremes
        write_capacity(4'd2);
        send_beat(OP_OFFER,  6'd0,  4'd0,  16'h0000, 32'd100);
        send_beat(OP_OFFER,  6'd0,  4'd0,  16'hFFFF, 32'd100);
        send_beat(OP_OFFER,  6'd0,  4'd0,  16'h0001, 32'd100);
        send_beat(OP_OFFER,  6'd0,  4'd0,  16'h0002, 32'd50);
        send_beat(OP_REMOVE, 6'd0,  4'd0,  16'h0002, 32'd51);
        send_beat(OP_REMOVE, 6'd0,  4'd0,  16'h0002, 32'd50);
        send_beat(OP_OFFER,  6'd0,  4'd0,  16'h0003, 32'd0);
        send_beat(OP_OFFER,  6'd0,  4'd0,  16'h0004, 32'hFFFF_FFFF);
        send_beat(OP_OFFER,  6'd63, 4'd15, 16'h0005, 32'hFFFF_FFFF);
        send_beat(OP_OFFER,  6'd63, 4'd15, 16'h0006, 32'hFFFF_FFFF);
        send_beat(OP_OFFER,  6'd63, 4'd15, 16'h0007, 32'hFFFF_FFFE);
        send_beat(OP_REMOVE, 6'd63, 4'd15, 16'h0005, 32'hFFFF_FFFF);
        send_beat(OP_REMOVE, 6'd63, 4'd15, 16'h0005, 32'hFFFF_FFFF);
        // capacity zero acts as one, below the current fill
        write_capacity(4'd0);
        send_beat(OP_OFFER,  6'd0,  4'd0,  16'h0008, 32'd99);
        send_beat(OP_OFFER,  6'd0,  4'd0,  16'h0009, 32'd1000);
        send_beat(OP_OFFER,  6'd63, 4'd15, 16'h000A, 32'hFFFF_FFFE);
        // capacity above the slot count saturates
        write_capacity(4'd15);
        for (int i = 0; i < 8; i++) begin
            send_beat(OP_OFFER, 6'd0, 4'd0, 16'(16'h0100 + i), 32'(7 - (i % 3)));
        end

        for (int p = 0; p < 6; p++) begin
            write_capacity(phase_cap[p]);
            run_random_phase(PHASE_ITEMS, p == 2);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- latency_bounded_beacon_store.f -----
+incdir+hdl
hdl/lbbs_pkg.sv
hdl/lbbs_ram.sv
hdl/lbbs_update.sv
hdl/latency_bounded_beacon_store.sv
tb/sv/lbbs_checker.sv
tb/sv/tb.sv
